>>> rtl/dfam_pkg.sv
// dfam_pkg: shared types and constants of the table-driven DFA matcher.
// Used by dfam_sym_cam and table_driven_dfa_matcher_unit.
// No dependencies.
package dfam_pkg;

  // Sizes of the automaton
  localparam int NUM_STATES  = 32;
  localparam int NUM_SYMBOLS = 32;
  localparam int STATE_W     = $clog2(NUM_STATES);
  localparam int POS_W       = $clog2(NUM_SYMBOLS);
  localparam int CNT_W       = $clog2(NUM_SYMBOLS + 1);
  // Table entry: dead flag on top of the target state
  localparam int ENT_W       = STATE_W + 1;

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int FROM_W  = 5;
  localparam int SYM_W   = 8;
  localparam int TO_W    = 6;
  localparam int FINAL_W = 32;

  localparam logic [ENT_W-1:0] DEAD_ENTRY = {ENT_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_DEFINE = 2'd0,
    CMD_MARK   = 2'd1,
    CMD_CHAR   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    VC_ACCEPT   = 2'd0,
    VC_NONFINAL = 2'd1,
    VC_DEAD     = 2'd2,
    VC_UNKNOWN  = 2'd3
  } verdict_t;

  // Lookup result of the symbol store
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
    logic             full;
    logic [POS_W-1:0] free_pos;
  } cam_res_t;

endpackage

>>> rtl/dfam_sym_cam.sv
// dfam_sym_cam: alphabet store with parallel symbol match and in-order fill.
// Depends on dfam_pkg.
module dfam_sym_cam (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dfam_pkg::SYM_W-1:0]  symbol,
  input  logic                        add_en,
  output dfam_pkg::cam_res_t          res
);

  logic [dfam_pkg::SYM_W-1:0] sym_store [dfam_pkg::NUM_SYMBOLS];
  logic [dfam_pkg::CNT_W-1:0] count;
  logic [dfam_pkg::NUM_SYMBOLS-1:0] match;

  // Compare against every filled slot
  always_comb begin
    for (int i = 0; i < dfam_pkg::NUM_SYMBOLS; i++) begin
      match[i] = (dfam_pkg::CNT_W'(i) < count) && (sym_store[i] == symbol);
    end
  end

  // Lowest matching slot wins
  always_comb begin
    res.hit      = |match;
    res.pos      = '0;
    for (int i = dfam_pkg::NUM_SYMBOLS - 1; i >= 0; i--) begin
      if (match[i]) begin
        res.pos = dfam_pkg::POS_W'(i);
      end
    end
    res.full     = (count == dfam_pkg::CNT_W'(dfam_pkg::NUM_SYMBOLS));
    res.free_pos = count[dfam_pkg::POS_W-1:0];
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (add_en) begin
      count <= count + 1'b1;
    end
  end

  // Symbol slots, no reset: only filled slots are compared
  always_ff @(posedge clk) begin
    if (add_en) begin
      sym_store[count[dfam_pkg::POS_W-1:0]] <= symbol;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= dfam_pkg::CNT_W'(dfam_pkg::NUM_SYMBOLS))
    else $error("alphabet count past capacity");

  assert property (@(posedge clk) disable iff (rst)
    add_en |-> !res.full && !res.hit)
    else $error("symbol added while full or already present");

  assert property (@(posedge clk) disable iff (rst)
    res.hit |-> ({1'b0, res.pos} < count))
    else $error("match reported in an unfilled slot");

endmodule

>>> rtl/table_driven_dfa_matcher_unit.sv
// Programmable DFA string acceptor: define transitions, mark final states and
// step strings one character per item; one verdict item per finished string.
// Throughput is one item per cycle for any mix of commands; the input stalls
// only while a finished string's verdict waits on a held-off verdict stream.
// After its last character is taken, a verdict passes stage one, which matches the
// symbol and reads one table row (all states of that symbol), stage two, which picks
// the current state's entry and updates the string state, and then the result
// register. The transition table is organized by symbol slot
// and is written whole when a symbol first enters the alphabet, so it needs
// no clearing pass after reset and items are taken from the first cycle.
// Depends on dfam_pkg and dfam_sym_cam.
module table_driven_dfa_matcher_unit (
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] cmd, [6:2] from_state, [14:7] symbol, [20:15] to_state, [23:21] zero
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_char
  // Verdict items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] accepted, [2:1] verdict_code, [7:3] zero
  output logic [7:0]  m_axis_tdata
);

  localparam int NS = dfam_pkg::NUM_STATES;
  localparam int EW = dfam_pkg::ENT_W;

  // Stage one registers
  logic                         s1_valid;
  logic [dfam_pkg::CMD_W-1:0]   s1_cmd;
  logic [dfam_pkg::FROM_W-1:0]  s1_from;
  logic [dfam_pkg::SYM_W-1:0]   s1_sym;
  logic [dfam_pkg::TO_W-1:0]    s1_to;
  logic                         s1_last;

  // Stage two registers
  logic                         s2_valid;
  logic [dfam_pkg::CMD_W-1:0]   s2_cmd;
  logic                         s2_last;
  logic                         s2_hit;
  logic [NS-1:0][EW-1:0]        row_q;

  // String state
  logic [dfam_pkg::STATE_W-1:0] cur_state;
  logic                         aborted;
  dfam_pkg::verdict_t           reason;
  logic [dfam_pkg::FINAL_W-1:0] final_map;

  // Transition memory: one row per symbol slot
  logic [NS-1:0][EW-1:0] trans_mem [dfam_pkg::NUM_SYMBOLS];

  dfam_pkg::cam_res_t cam;
  logic               out_free, s2_go, s1_fire, accept;
  logic               from_ok, def_ok, add_en, mark_en;
  logic               to_dead;
  logic [EW-1:0]      wr_entry;
  logic [dfam_pkg::POS_W-1:0] wr_pos;

  logic                         is_char, produce;
  logic [EW-1:0]                entry;
  logic [dfam_pkg::STATE_W-1:0] state_next;
  logic                         aborted_next;
  dfam_pkg::verdict_t           reason_next;
  dfam_pkg::verdict_t           verdict;

  // Flow control
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s2_go         = !s2_valid || !produce || out_free;
  assign s1_fire       = s1_valid && s2_go;
  assign s_axis_tready = !s1_valid || s2_go;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= s_axis_tdata[1:0];
      s1_from <= s_axis_tdata[6:2];
      s1_sym  <= s_axis_tdata[14:7];
      s1_to   <= s_axis_tdata[20:15];
      s1_last <= s_axis_tlast;
    end
  end

  dfam_sym_cam u_cam (
    .clk    (clk),
    .rst    (rst),
    .symbol (s1_sym),
    .add_en (add_en),
    .res    (cam)
  );

  // Stage one: define and mark decode
  always_comb begin
    from_ok  = 32'(s1_from) < 32'(NS);
    def_ok   = s1_fire && (s1_cmd == dfam_pkg::CMD_DEFINE) && from_ok
               && (cam.hit || !cam.full);
    add_en   = def_ok && !cam.hit;
    mark_en  = s1_fire && (s1_cmd == dfam_pkg::CMD_MARK) && from_ok;
    wr_pos   = cam.hit ? cam.pos : cam.free_pos;
    to_dead  = s1_to[dfam_pkg::TO_W-1]
               || (32'(s1_to[dfam_pkg::TO_W-2:0]) >= 32'(NS));
    wr_entry = to_dead ? dfam_pkg::DEAD_ENTRY
                       : {1'b0, s1_to[dfam_pkg::STATE_W-1:0]};
  end

  // Table write: a new slot gets its whole row, others one lane
  always_ff @(posedge clk) begin
    if (def_ok) begin
      for (int l = 0; l < NS; l++) begin
        if (add_en || (32'(s1_from) == 32'(l))) begin
          trans_mem[wr_pos][l] <= (32'(s1_from) == 32'(l)) ? wr_entry
                                                          : dfam_pkg::DEAD_ENTRY;
        end
      end
    end
  end

  // Table read for string characters
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      row_q <= trans_mem[cam.pos];
    end
  end

  // Final-state map
  always_ff @(posedge clk) begin
    if (rst) begin
      final_map <= '0;
    end else if (mark_en) begin
      final_map <= final_map | (dfam_pkg::FINAL_W'(1) << s1_from);
    end
  end

  // Stage two registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_go) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_cmd  <= s1_cmd;
      s2_last <= s1_last;
      s2_hit  <= cam.hit;
    end
  end

  // Stage two: step the automaton and form the verdict
  always_comb begin
    is_char      = s2_valid && (s2_cmd == dfam_pkg::CMD_CHAR);
    produce      = is_char && s2_last;
    entry        = row_q[cur_state];
    state_next   = cur_state;
    aborted_next = aborted;
    reason_next  = reason;
    if (!aborted) begin
      if (!s2_hit) begin
        aborted_next = 1'b1;
        reason_next  = dfam_pkg::VC_UNKNOWN;
      end else if (entry[EW-1]) begin
        aborted_next = 1'b1;
        reason_next  = dfam_pkg::VC_DEAD;
      end else begin
        state_next = entry[dfam_pkg::STATE_W-1:0];
      end
    end
    if (aborted_next) begin
      verdict = reason_next;
    end else if (final_map[state_next]) begin
      verdict = dfam_pkg::VC_ACCEPT;
    end else begin
      verdict = dfam_pkg::VC_NONFINAL;
    end
  end

  // String state; a finished string starts over from state zero
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= '0;
      aborted   <= 1'b0;
      reason    <= dfam_pkg::VC_ACCEPT;
    end else if (is_char && s2_go) begin
      if (s2_last) begin
        cur_state <= '0;
        aborted   <= 1'b0;
        reason    <= dfam_pkg::VC_ACCEPT;
      end else begin
        cur_state <= state_next;
        aborted   <= aborted_next;
        reason    <= reason_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (produce && out_free) begin
      m_axis_tdata <= {5'd0, verdict, (verdict == dfam_pkg::VC_ACCEPT)};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == dfam_pkg::VC_ACCEPT)))
    else $error("accepted flag disagrees with verdict code");

  assert property (@(posedge clk) disable iff (rst)
    aborted |-> (reason == dfam_pkg::VC_DEAD || reason == dfam_pkg::VC_UNKNOWN))
    else $error("aborted string without an abort reason");

  assert property (@(posedge clk) disable iff (rst)
    (produce && s2_go) |=> (cur_state == '0 && !aborted && m_axis_tvalid))
    else $error("string state not cleared after verdict");

  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_go) |=> (s1_valid && $stable(s1_sym) && $stable(s1_cmd)))
    else $error("stalled item lost from stage one");

endmodule

>>> tb/table_driven_dfa_matcher_checker.sv
// table_driven_dfa_matcher_checker: watches the item and verdict streams of the
// DFA matcher, keeps its own copy of the automaton, predicts each string verdict.
// Depends on dfam_pkg.
module table_driven_dfa_matcher_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [1:0] cmd, [6:2] from_state, [14:7] symbol, [20:15] to_state, [23:21] zero
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_char
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] accepted, [2:1] verdict_code, [7:3] zero
  input  logic [7:0]  m_axis_tdata,
  output int          fail_count,
  output int          pending
);

  // Input item layout, lowest field last
  typedef struct packed {
    logic [2:0]                   pad;
    logic [dfam_pkg::TO_W-1:0]    to_state;
    logic [dfam_pkg::SYM_W-1:0]   symbol;
    logic [dfam_pkg::FROM_W-1:0]  from_state;
    logic [dfam_pkg::CMD_W-1:0]   cmd;
  } dfa_item_t;

  typedef struct packed {
    logic [4:0]          pad;
    dfam_pkg::verdict_t  code;
    logic                accepted;
  } verdict_item_t;

  // Automaton copy: table of next states, indexed by state and alphabet slot
  bit                          edge_dead [dfam_pkg::NUM_STATES][dfam_pkg::NUM_SYMBOLS];
  bit [dfam_pkg::STATE_W-1:0]  edge_next [dfam_pkg::NUM_STATES][dfam_pkg::NUM_SYMBOLS];
  bit [dfam_pkg::SYM_W-1:0]    sym_store [dfam_pkg::NUM_SYMBOLS];
  int                          sym_count;
  bit [dfam_pkg::FINAL_W-1:0]  final_states;
  // String in progress
  bit [dfam_pkg::STATE_W-1:0]  walk_state;
  bit                          walk_aborted;
  dfam_pkg::verdict_t          abort_code;

  verdict_item_t     expected_verdicts[$];

  function automatic int lookup_slot(input logic [dfam_pkg::SYM_W-1:0] sym);
    for (int i = 0; i < sym_count; i++)
      if (sym_store[i] == sym) return i;
    return -1;
  endfunction

  function automatic void clear_walk();
    walk_state   = '0;
    walk_aborted = 1'b0;
    abort_code   = dfam_pkg::VC_ACCEPT;
  endfunction

  function automatic void clear_automaton();
    for (int s = 0; s < dfam_pkg::NUM_STATES; s++)
      for (int k = 0; k < dfam_pkg::NUM_SYMBOLS; k++) begin
        edge_dead[s][k] = 1'b1;
        edge_next[s][k] = '0;
      end
    sym_count    = 0;
    final_states = '0;
    clear_walk();
    expected_verdicts.delete();
  endfunction

  // One accepted input item: update the automaton, queue a verdict on a last char
  function automatic void advance_automaton(input dfa_item_t it, input logic last);
    int            slot;
    verdict_item_t v;
    slot = lookup_slot(it.symbol);
    case (it.cmd)
      dfam_pkg::CMD_DEFINE: begin
        if (it.from_state < dfam_pkg::NUM_STATES) begin
          if (slot < 0 && sym_count < dfam_pkg::NUM_SYMBOLS) begin
            sym_store[sym_count] = it.symbol;
            slot = sym_count;
            sym_count++;
          end
          // new symbol with a full alphabet: whole item dropped
          if (slot >= 0) begin
            edge_dead[it.from_state][slot] = it.to_state[dfam_pkg::TO_W-1]
                                             || (it.to_state >= dfam_pkg::NUM_STATES);
            edge_next[it.from_state][slot] = it.to_state[dfam_pkg::STATE_W-1:0];
          end
        end
      end
      dfam_pkg::CMD_MARK: begin
        if (it.from_state < dfam_pkg::NUM_STATES) final_states[it.from_state] = 1'b1;
      end
      dfam_pkg::CMD_CHAR: begin
        // first abort reason sticks until the string ends
        if (!walk_aborted) begin
          if (slot < 0) begin
            walk_aborted = 1'b1;
            abort_code   = dfam_pkg::VC_UNKNOWN;
          end else if (edge_dead[walk_state][slot]) begin
            walk_aborted = 1'b1;
            abort_code   = dfam_pkg::VC_DEAD;
          end else begin
            walk_state = edge_next[walk_state][slot];
          end
        end
        if (last) begin
          v = '0;
          if (walk_aborted) v.code = abort_code;
          else if (final_states[walk_state]) v.code = dfam_pkg::VC_ACCEPT;
          else v.code = dfam_pkg::VC_NONFINAL;
          v.accepted = (v.code == dfam_pkg::VC_ACCEPT);
          expected_verdicts.push_back(v);
          clear_walk();
        end
      end
      default: ;  // unused command
    endcase
  endfunction

  // Compare one verdict item with the oldest expectation
  always @(posedge clk) begin
    verdict_item_t got, exp_v;
    if (rst) begin
      clear_automaton();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_verdicts.size() == 0) begin
          $error("verdict item with no string ended: accepted %0d code %0d",
                 got.accepted, got.code);
          fail_count++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (got.accepted !== exp_v.accepted) begin
            $error("accepted mismatch: expected %0d, got %0d", exp_v.accepted, got.accepted);
            fail_count++;
          end
          if (got.code !== exp_v.code) begin
            $error("verdict_code mismatch: expected %0d, got %0d", exp_v.code, got.code);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) advance_automaton(s_axis_tdata, s_axis_tlast);
    end
    pending = expected_verdicts.size();
  end

endmodule

>>> tb/table_driven_dfa_matcher_unit_test.sv
// table_driven_dfa_matcher_unit_test: drives automaton definitions and strings
// into the DFA matcher with random idling and backpressure, and gives the verdict.
// Depends on dfam_pkg, table_driven_dfa_matcher_unit and table_driven_dfa_matcher_checker.
module table_driven_dfa_matcher_unit_test;

  localparam logic [dfam_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE1_ITEMS   = 1150;
  localparam int PHASE2_ITEMS   = 400;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int DENSE_STATES   = 8;
  localparam int MARK_RANGE     = 23;

  // Symbols of the directed part
  localparam logic [dfam_pkg::SYM_W-1:0] SYM_A    = 8'h61;
  localparam logic [dfam_pkg::SYM_W-1:0] SYM_LO   = 8'h00;
  localparam logic [dfam_pkg::SYM_W-1:0] SYM_HI   = 8'hFF;
  localparam logic [dfam_pkg::SYM_W-1:0] SYM_ODD  = 8'h5A;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  int fail_count, pending;
  int idle_cycles = 0;
  int sent = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  // Symbols in the order the block stores them
  logic [dfam_pkg::SYM_W-1:0] alphabet_pool[$];

  always #1 clk = ~clk;

  table_driven_dfa_matcher_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  table_driven_dfa_matcher_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Offer one item after an optional gap; returns at the falling edge after it is taken
  task automatic send_item(input logic [dfam_pkg::CMD_W-1:0] cmd,
                           input logic [dfam_pkg::FROM_W-1:0] from,
                           input logic [dfam_pkg::SYM_W-1:0] sym,
                           input logic [dfam_pkg::TO_W-1:0] to,
                           input logic last);
    bit known;
    known = 1'b0;
    foreach (alphabet_pool[i]) if (alphabet_pool[i] == sym) known = 1'b1;
    if (cmd == dfam_pkg::CMD_DEFINE && !known && alphabet_pool.size() < dfam_pkg::NUM_SYMBOLS)
      alphabet_pool.push_back(sym);
    if (cmd != CMD_UNUSED) sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_axis_tdata  = {3'b000, to, sym, from, cmd};
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Mostly the first few stored symbols, so walks meet defined edges
  function automatic logic [dfam_pkg::SYM_W-1:0] pick_symbol();
    int n;
    n = alphabet_pool.size();
    if (n == 0 || $urandom_range(0, 9) == 0)
      return dfam_pkg::SYM_W'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 7)
      return alphabet_pool[$urandom_range(0, (n < DENSE_STATES ? n : DENSE_STATES) - 1)];
    return alphabet_pool[$urandom_range(0, n - 1)];
  endfunction

  task automatic random_define();
    logic [dfam_pkg::FROM_W-1:0] from;
    logic [dfam_pkg::TO_W-1:0]   to;
    int                          r;
    from = ($urandom_range(0, 3) != 0)
           ? dfam_pkg::FROM_W'($urandom_range(0, DENSE_STATES - 1))
           : dfam_pkg::FROM_W'($urandom_range(0, dfam_pkg::NUM_STATES - 1));
    r = $urandom_range(0, 19);
    if (r < 14) to = dfam_pkg::TO_W'($urandom_range(0, DENSE_STATES - 1));
    else if (r < 17) to = dfam_pkg::TO_W'($urandom_range(0, dfam_pkg::NUM_STATES - 1));
    else to = dfam_pkg::TO_W'($urandom_range(dfam_pkg::NUM_STATES, 63));  // negative: dead
    send_item(dfam_pkg::CMD_DEFINE, from, pick_symbol(), to, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_string(input int len);
    for (int k = 0; k < len; k++) begin
      // table edits land in the middle of a string now and then
      if ($urandom_range(0, 19) == 0) random_define();
      send_item(dfam_pkg::CMD_CHAR, dfam_pkg::FROM_W'($urandom), pick_symbol(),
                dfam_pkg::TO_W'($urandom), k == len - 1);
    end
  endtask

  task automatic run_random(input int n);
    int r, goal;
    goal = sent + n;
    while (sent < goal) begin
      if (!quiet && !hold_req && sent >= HOLD_AT) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 18) random_define();
      else if (r < 20)
        send_item(dfam_pkg::CMD_MARK, dfam_pkg::FROM_W'($urandom_range(0, MARK_RANGE)),
                  dfam_pkg::SYM_W'($urandom), dfam_pkg::TO_W'($urandom),
                  1'($urandom_range(0, 1)));
      else if (r < 22)
        send_item(CMD_UNUSED, dfam_pkg::FROM_W'($urandom), dfam_pkg::SYM_W'($urandom),
                  dfam_pkg::TO_W'($urandom), 1'($urandom_range(0, 1)));
      else send_string($urandom_range(1, 6));
    end
  endtask

  // Verdict receiver: short random stalls, one long hold-off, none at the end
  initial begin
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        m_axis_tready = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Watchdog on cycles with no item taken on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty alphabet, field extremes, every command, each abort path
    send_item(CMD_UNUSED,           5'd31, SYM_HI,  6'h3F, 1'b1);   // ignored, no verdict
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_HI,  6'd0,  1'b1);   // unknown, alphabet empty
    send_item(dfam_pkg::CMD_DEFINE, 5'd0,  SYM_A,   6'd1,  1'b0);
    send_item(dfam_pkg::CMD_DEFINE, 5'd1,  SYM_LO,  6'd31, 1'b1);
    send_item(dfam_pkg::CMD_DEFINE, 5'd31, SYM_HI,  6'h3F, 1'b0);   // -1: dead
    send_item(dfam_pkg::CMD_DEFINE, 5'd31, SYM_A,   6'h20, 1'b0);   // most negative: dead
    send_item(dfam_pkg::CMD_MARK,   5'd31, SYM_LO,  6'd0,  1'b0);
    send_item(dfam_pkg::CMD_CHAR,   5'd31, SYM_A,   6'h3F, 1'b1);   // ends in non-final 1
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_A,   6'd0,  1'b0);
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_LO,  6'd0,  1'b1);   // accepted in 31
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_A,   6'd0,  1'b0);
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_LO,  6'd0,  1'b0);
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_HI,  6'd0,  1'b1);   // dead on the last char
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_A,   6'd0,  1'b0);
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_HI,  6'd0,  1'b0);   // dead, never defined
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_ODD, 6'd0,  1'b0);   // ignored after abort
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_LO,  6'd0,  1'b1);   // still reports dead
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_ODD, 6'd0,  1'b0);   // unknown symbol
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_A,   6'd0,  1'b1);
    send_item(dfam_pkg::CMD_MARK,   5'd0,  SYM_HI,  6'h3F, 1'b1);
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_A,   6'd0,  1'b0);   // now in 1
    send_item(dfam_pkg::CMD_DEFINE, 5'd1,  SYM_A,   6'd0,  1'b0);   // edit mid-string
    send_item(dfam_pkg::CMD_CHAR,   5'd0,  SYM_A,   6'd0,  1'b1);   // back to final 0

    run_random(PHASE1_ITEMS);
    quiet = 1'b1;
    run_random(PHASE2_ITEMS);
    s_axis_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
